// File: hdl/window_median_depth_backproject_macros.svh
// Assertion helpers used by the top-level RTL file
`ifndef WINDOW_MEDIAN_DEPTH_BACKPROJECT_MACROS_SVH
`define WINDOW_MEDIAN_DEPTH_BACKPROJECT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define WMDB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define WMDB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wmdb_pkg.sv
`timescale 1ns / 1ps
package wmdb_pkg;

    localparam int COORD_W = 12;
    localparam int DEPTH_W = 16;
    localparam int GAIN_W  = 32;
    localparam int OUT_W   = 24;
    localparam int FRAC_W  = 30;
    localparam int SUM_W   = 48;
    localparam int NUM_REGS = 5;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_X_COL_GAIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_ROW_GAIN = 3'd1;
    localparam logic [IDX_W-1:0] REG_X_OFFSET   = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_ROW_GAIN = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y_OFFSET   = 3'd4;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
        logic [DEPTH_W-1:0] depth_value;
        logic               depth_present;
        logic               region_end;
    } pixel_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
        logic [DEPTH_W-1:0]      point_z;
        logic                    last_point;
    } point_t;

    // One window slot as held by a cell
    typedef struct packed {
        logic               full;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [DEPTH_W-1:0] depth;
    } slot_t;

    // Control handed from the window sequencer to the projection stage
    typedef struct packed {
        logic               go;
        logic               last;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [DEPTH_W-1:0] median;
    } emit_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] x_col_gain;
        logic signed [GAIN_W-1:0] x_row_gain;
        logic signed [GAIN_W-1:0] x_offset;
        logic signed [GAIN_W-1:0] y_row_gain;
        logic signed [GAIN_W-1:0] y_offset;
    } gains_t;

endpackage

// File: hdl/wmdb_cell.sv
`timescale 1ns / 1ps
// One window slot: loads from the input, shifts in from its right neighbour, or clears
module wmdb_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  logic           shift,
    input  logic           load,
    input  wmdb_pkg::slot_t from_right,
    input  wmdb_pkg::slot_t load_data,
    output wmdb_pkg::slot_t slot
);
    import wmdb_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (clear)
        begin
            slot_next = '0;
        end
        else if (load)
        begin
            slot_next = load_data;
        end
        else if (shift)
        begin
            slot_next = from_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

// File: hdl/wmdb_median.sv
`timescale 1ns / 1ps
// Median of the selected slots, one comparison round per cycle (odd-even transposition)
module wmdb_median #(
    parameter int WIN = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [WIN-1:0]                      sel,
    input  logic [WIN-1:0][wmdb_pkg::DEPTH_W-1:0] depths,
    output logic                                done,
    output logic [wmdb_pkg::DEPTH_W-1:0]        median
);
    import wmdb_pkg::*;

    localparam int RW = $clog2(WIN + 2);
    localparam int CW = $clog2(WIN + 1);

    // unused slots hold the maximum so they settle at the top
    logic [WIN-1:0][DEPTH_W-1:0] v_reg, v_next;
    logic [RW-1:0] round_reg, round_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DEPTH_W:0] pair_sum;
    logic [CW-1:0] half_idx;

    always_comb
    begin
        v_next = v_reg;
        round_next = round_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = '0;
            for (int i = 0; i < WIN; i++)
            begin
                v_next[i] = sel[i] ? depths[i] : {DEPTH_W{1'b1}};
                cnt_next = cnt_next + CW'(sel[i]);
            end
            round_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // even rounds compare pairs from slot 0, odd rounds from slot 1
            for (int i = 0; i + 1 < WIN; i++)
            begin
                if ((i[0] == round_reg[0]) && (v_reg[i] > v_reg[i+1]))
                begin
                    v_next[i] = v_reg[i+1];
                    v_next[i+1] = v_reg[i];
                end
            end
            round_next = round_reg + 1'b1;
            if (round_reg == RW'(WIN - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            round_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            round_reg <= round_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign half_idx = cnt_reg >> 1;
    always_comb
    begin
        pair_sum = '0;
        median = '0;
        if (cnt_reg[0])
        begin
            median = v_reg[half_idx];
        end
        else if (cnt_reg != '0)
        begin
            pair_sum = {1'b0, v_reg[half_idx]} + {1'b0, v_reg[half_idx - 1'b1]};
            median = pair_sum[DEPTH_W:1];
        end
    end
    assign done = done_reg;

endmodule

// File: hdl/wmdb_project.sv
`timescale 1ns / 1ps
// Back-projection: gains times coordinates, then times the median, floor and clamp
module wmdb_project (
    input  logic             clk,
    input  logic             rst_n,
    input  wmdb_pkg::emit_t  emit,
    input  wmdb_pkg::gains_t gains,
    output logic             valid,
    output wmdb_pkg::point_t point
);
    import wmdb_pkg::*;

    localparam int PROD_W = SUM_W + DEPTH_W + 1;
    localparam logic signed [PROD_W-1:0] MAXV = PROD_W'(24'sh7FFFFF);
    localparam logic signed [PROD_W-1:0] MINV = -PROD_W'(25'sh800000);

    logic [2:0] stage_reg;
    logic signed [SUM_W-1:0] ax_reg, bx_reg, ay_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, fx, fy;
    logic [DEPTH_W-1:0] m_reg;
    logic last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], emit.go};
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.go)
        begin
            ax_reg <= SUM_W'(gains.x_col_gain * $signed({1'b0, emit.col}));
            bx_reg <= SUM_W'(gains.x_row_gain * $signed({1'b0, emit.row}));
            ay_reg <= SUM_W'(gains.y_row_gain * $signed({1'b0, emit.row}));
            m_reg <= emit.median;
            last_reg <= emit.last;
        end
        sx_reg <= ax_reg + bx_reg + SUM_W'(gains.x_offset);
        sy_reg <= ay_reg + SUM_W'(gains.y_offset);
        px_reg <= PROD_W'(sx_reg * $signed({1'b0, m_reg}));
        py_reg <= PROD_W'(sy_reg * $signed({1'b0, m_reg}));
    end

    assign fx = px_reg >>> FRAC_W;
    assign fy = py_reg >>> FRAC_W;

    always_comb
    begin
        point.point_x = (fx > MAXV) ? 24'sh7FFFFF : (fx < MINV) ? 24'sh800000 : fx[OUT_W-1:0];
        point.point_y = (fy > MAXV) ? 24'sh7FFFFF : (fy < MINV) ? 24'sh800000 : fy[OUT_W-1:0];
        point.point_z = m_reg;
        point.last_point = last_reg;
    end
    assign valid = stage_reg[2];

endmodule

// File: hdl/window_median_depth_backproject.sv
`timescale 1ns / 1ps
// Streams region pixels through a row of window cells and emits back-projected,
// median-filtered points. A pixel that yields no point does not hold the input. A
// pixel that yields a point holds the input while the block starts the median, runs
// 2*HALF_WINDOW+1 transposition rounds, passes three projection stages, sees the
// result and moves it into the output register. A region end with k points pending
// holds the input through that sequence once per point, plus any wait on
// out_stall while the output register still holds an untaken point.
module window_median_depth_backproject #(
    parameter int HALF_WINDOW = 2,
    parameter int DEPTH_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  wmdb_pkg::pixel_t           in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output wmdb_pkg::point_t           out_data,
    input  logic                       cfg_we,
    input  logic [wmdb_pkg::IDX_W-1:0] cfg_index,
    input  logic [wmdb_pkg::GAIN_W-1:0] cfg_data
);
    import wmdb_pkg::*;
    `include "window_median_depth_backproject_macros.svh"

    localparam int WIN = 2 * HALF_WINDOW + 1;
    localparam int PW = $clog2(WIN + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MASK = DEPTH_W'((64'd1 << DEPTH_BITS) - 64'd1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_PROJ = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    gains_t gains_reg;
    logic [1:0] state_reg, state_next;
    logic [PW-1:0] kept_reg, kept_next, emit_reg, emit_next;
    logic flush_reg, flush_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] lo_pos, hi_pos;
    logic last_reg, last_next;
    point_t out_reg;
    logic out_valid_reg;

    slot_t [WIN-1:0] slots;
    slot_t load_slot;
    logic [WIN-1:0] load_vec;
    logic clear_all, do_shift, accept, in_present;
    logic [PW-1:0] ins_pos, kept_after;

    logic med_start, med_done;
    logic [WIN-1:0] med_sel;
    logic [WIN-1:0][DEPTH_W-1:0] med_depths;
    logic [DEPTH_W-1:0] med_value;
    emit_t emit;
    logic proj_valid;
    point_t proj_point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.x_col_gain <= GAIN_ONE;
            gains_reg.x_row_gain <= '0;
            gains_reg.x_offset <= '0;
            gains_reg.y_row_gain <= GAIN_ONE;
            gains_reg.y_offset <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_COL_GAIN: gains_reg.x_col_gain <= cfg_data;
                REG_X_ROW_GAIN: gains_reg.x_row_gain <= cfg_data;
                REG_X_OFFSET:   gains_reg.x_offset <= cfg_data;
                REG_Y_ROW_GAIN: gains_reg.y_row_gain <= cfg_data;
                REG_Y_OFFSET:   gains_reg.y_offset <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;
    assign in_present = in_data.depth_present;
    assign do_shift = accept && in_present && (kept_reg == PW'(WIN));
    assign ins_pos = do_shift ? PW'(WIN - 1) : kept_reg;
    assign kept_after = do_shift ? kept_reg : kept_reg + 1'b1;

    always_comb
    begin
        load_slot.full = 1'b1;
        load_slot.col = in_data.pixel_col;
        load_slot.row = in_data.pixel_row;
        load_slot.depth = in_data.depth_value & DEPTH_MASK;
        for (int i = 0; i < WIN; i++)
        begin
            load_vec[i] = accept && in_present && (ins_pos == PW'(i));
        end
    end

    genvar g;
    generate
        for (g = 0; g < WIN; g++)
        begin : g_cell
            slot_t right;
            if (g == WIN - 1)
            begin : g_edge
                assign right = '0;
            end
            else
            begin : g_inner
                assign right = slots[g+1];
            end
            wmdb_cell u_cell (
                .clk(clk), .rst_n(rst_n), .clear(clear_all), .shift(do_shift),
                .load(load_vec[g]), .from_right(right), .load_data(load_slot),
                .slot(slots[g])
            );
        end
    endgenerate

    assign lo_pos = (pos_reg >= PW'(HALF_WINDOW)) ? pos_reg - PW'(HALF_WINDOW) : '0;
    assign hi_pos = (pos_reg + PW'(HALF_WINDOW) > kept_reg - 1'b1) ? kept_reg - 1'b1
                                                                  : pos_reg + PW'(HALF_WINDOW);
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            med_sel[i] = (PW'(i) >= lo_pos) && (PW'(i) <= hi_pos);
            med_depths[i] = slots[i].depth;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kept_next = kept_reg;
        emit_next = emit_reg;
        flush_next = flush_reg;
        pos_next = pos_reg;
        last_next = last_reg;
        clear_all = 1'b0;
        med_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_present)
                    begin
                        kept_next = kept_after;
                        if (do_shift && emit_reg != '0)
                        begin
                            emit_next = emit_reg - 1'b1;
                        end
                    end
                    flush_next = in_data.region_end;
                    if (in_data.region_end)
                    begin
                        if (emit_next < kept_next)
                        begin
                            state_next = ST_SORT;
                        end
                        else
                        begin
                            clear_all = 1'b1;
                            kept_next = '0;
                            emit_next = '0;
                        end
                    end
                    else if (in_present && (kept_next - emit_next > PW'(HALF_WINDOW)))
                    begin
                        state_next = ST_SORT;
                    end
                    pos_next = emit_next;
                end
            end
            ST_SORT:
            begin
                med_start = 1'b1;
                last_next = flush_reg && (pos_reg + 1'b1 == kept_reg);
                state_next = ST_PROJ;
            end
            ST_PROJ:
            begin
                if (proj_valid)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (flush_reg && (pos_reg + 1'b1 < kept_reg))
                    begin
                        pos_next = pos_reg + 1'b1;
                        state_next = ST_SORT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        if (flush_reg)
                        begin
                            clear_all = 1'b1;
                            kept_next = '0;
                            emit_next = '0;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    wmdb_median #(.WIN(WIN)) u_median (
        .clk(clk), .rst_n(rst_n), .start(med_start), .sel(med_sel),
        .depths(med_depths), .done(med_done), .median(med_value)
    );

    always_comb
    begin
        emit.go = med_done;
        emit.last = last_reg;
        emit.col = slots[pos_reg[$clog2(WIN)-1:0]].col;
        emit.row = slots[pos_reg[$clog2(WIN)-1:0]].row;
        emit.median = med_value;
    end

    wmdb_project u_project (
        .clk(clk), .rst_n(rst_n), .emit(emit), .gains(gains_reg),
        .valid(proj_valid), .point(proj_point)
    );

    // load the point only once the output register is free; the projection holds meanwhile
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
        begin
            out_reg <= proj_point;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kept_reg <= '0;
            emit_reg <= '0;
            flush_reg <= 1'b0;
            pos_reg <= '0;
            last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kept_reg <= kept_next;
            emit_reg <= emit_next;
            flush_reg <= flush_next;
            pos_reg <= pos_next;
            last_reg <= last_next;
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // a point goes out only after its projection is latched
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `WMDB_ASSERT_IMP(a_kept_bound, clk, rst_n, 1'b1, kept_reg <= PW'(WIN), "kept count overflow")
    `WMDB_ASSERT_IMP(a_emit_bound, clk, rst_n, 1'b1, emit_reg <= kept_reg, "emit index past kept")
    `WMDB_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !accept, "item taken while busy")
    `WMDB_ASSERT_NEXT(a_sort_start, clk, rst_n, state_reg == ST_SORT, state_reg == ST_PROJ, "sort did not start")

endmodule
